// File: sv/itv16_pkg.sv
// shared types and constants for the 16-bit interval timer
`timescale 1ns / 1ps
package itv16_pkg;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_LATCH_LO = 3'd1,
    OP_LATCH_HI = 3'd2,
    OP_CONTROL  = 3'd3,
    OP_READ     = 3'd4,
    OP_PULSE    = 3'd5
  } op_e;

  // control byte bit positions
  localparam int unsigned CtrlStartBit   = 0;
  localparam int unsigned CtrlOneshotBit = 3;
  localparam int unsigned CtrlLoadBit    = 4;

  localparam logic [15:0] CountReset = 16'hffff;

  // one queued start, stop or load request
  typedef struct packed {
    logic load;
    logic run;
    logic valid;
  } pend_t;

  // one result word
  typedef struct packed {
    logic [15:0] read_value;
    logic        underflow;
    logic        is_running;
  } result_t;

endpackage

// File: sv/itv16_core.sv
// timer state and single-pass next-state and result logic
`timescale 1ns / 1ps
module itv16_core #(
  parameter int unsigned START_DELAY = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  itv16_pkg::op_e      op_i,
  input  logic [7:0]          data_i,
  output itv16_pkg::result_t  result_o
);

  logic [15:0]      cnt_q, cnt_d;
  logic [15:0]      latch_q, latch_d;
  logic             run_q, run_d;
  logic             oneshot_q, oneshot_d;
  itv16_pkg::pend_t pend_q [START_DELAY];
  itv16_pkg::pend_t pend_d [START_DELAY];

  logic             wrap;
  logic [15:0]      cnt_step;
  itv16_pkg::pend_t leaving;

  // one counting step: reload from latch at zero, else decrement
  assign wrap     = (cnt_q == 16'd0);
  assign cnt_step = wrap ? latch_q : (cnt_q - 16'd1);
  assign leaving  = pend_q[START_DELAY-1];

  always_comb begin
    cnt_d               = cnt_q;
    latch_d             = latch_q;
    run_d               = run_q;
    oneshot_d           = oneshot_q;
    pend_d              = pend_q;
    result_o.read_value = '0;
    result_o.underflow  = 1'b0;
    unique case (op_i)
      itv16_pkg::OP_TICK: begin
        if (run_q) begin
          cnt_d              = cnt_step;
          result_o.underflow = wrap;
          if (wrap && oneshot_q) begin
            run_d = 1'b0;
          end
        end
        for (int i = START_DELAY - 1; i > 0; i--) begin
          pend_d[i] = pend_q[i-1];
        end
        pend_d[0] = '0;
        if (leaving.valid) begin
          if (leaving.load) begin
            cnt_d = latch_q;
          end
          run_d = leaving.run;
        end
      end
      itv16_pkg::OP_LATCH_LO: begin
        latch_d = {latch_q[15:8], data_i};
        if (!run_q) begin
          cnt_d = latch_d;
        end
      end
      itv16_pkg::OP_LATCH_HI: begin
        latch_d = {data_i, latch_q[7:0]};
        if (!run_q) begin
          cnt_d = latch_d;
        end
      end
      itv16_pkg::OP_CONTROL: begin
        oneshot_d       = data_i[itv16_pkg::CtrlOneshotBit];
        pend_d[0].valid = 1'b1;
        pend_d[0].run   = data_i[itv16_pkg::CtrlStartBit];
        pend_d[0].load  = data_i[itv16_pkg::CtrlLoadBit];
      end
      itv16_pkg::OP_READ: begin
        result_o.read_value = wrap ? latch_q : cnt_q;
      end
      itv16_pkg::OP_PULSE: begin
        // pulses count whatever the run state
        cnt_d              = cnt_step;
        result_o.underflow = wrap;
        if (wrap && oneshot_q) begin
          run_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
    result_o.is_running = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= itv16_pkg::CountReset;
      latch_q   <= itv16_pkg::CountReset;
      run_q     <= 1'b0;
      oneshot_q <= 1'b0;
      for (int i = 0; i < START_DELAY; i++) begin
        pend_q[i] <= '0;
      end
    end else if (step_en_i) begin
      cnt_q     <= cnt_d;
      latch_q   <= latch_d;
      run_q     <= run_d;
      oneshot_q <= oneshot_d;
      pend_q    <= pend_d;
    end
  end

endmodule

// File: sv/interval_timer_16bit_top.sv
// top level of the 16-bit interval timer with output register and handshake
// the result word of an accepted word is registered and shows in the cycle after it is accepted
// throughput: one word per cycle while the input is not stalled, set by the state update in the core
// the input side is stalled only while a finished result waits and the output stalls
// reset: asynchronous, active low; counter and latch go to all ones, timer stopped,
// one-shot off, no queued control requests, output register empty
`timescale 1ns / 1ps
module interval_timer_16bit_top #(
  parameter int unsigned START_DELAY = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  data_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_value_o,
  output logic        underflow_o,
  output logic        is_running_o
);

  logic               in_accept;
  logic               out_valid_q, out_valid_d;
  itv16_pkg::result_t result_c;
  itv16_pkg::result_t result_q;

  // a new word may enter whenever the result register is free or being drained
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // state and next-state logic; state advances only on an accepted word
  itv16_core #(
    .START_DELAY(START_DELAY)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_en_i(in_accept),
    .op_i     (itv16_pkg::op_e'(op_i)),
    .data_i   (data_i),
    .result_o (result_c)
  );

  // output register: loads on accept, holds while stalled, empties when taken
  always_comb begin
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result_c;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = result_q.read_value;
  assign underflow_o  = result_q.underflow;
  assign is_running_o = result_q.is_running;

`ifndef SYNTHESIS
  // a waiting result is never overwritten by a new word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input accepted while result word is held");

  // every accepted word produces a result word on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted word produced no result");

  // only reads show a value, and an underflow comes from a count step, never a read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && underflow_o) |-> (read_value_o == 16'd0))
    else $error("underflow flagged together with a read value");
`endif

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for the 16-bit interval timer top level
`timescale 1ns / 1ps
module tb;

  localparam int unsigned StartDelay  = 2;
  localparam logic [2:0]  OpSpare6    = 3'd6;
  localparam logic [2:0]  OpSpare7    = 3'd7;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldOffLen  = 300;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [2:0]  op_i        = itv16_pkg::OP_TICK;
  logic [7:0]  data_i      = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] read_value_o;
  logic        underflow_o;
  logic        is_running_o;

  // idle and stall odds in percent, changed between phases
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // cycles left in a forced output hold-off
  int unsigned hold_left      = 0;

  int unsigned cycle_count     = 0;
  int unsigned mismatches      = 0;
  int unsigned words_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned underflows_seen = 0;
  int unsigned reads_seen      = 0;
  int unsigned in_stall_cycles = 0;

  // predicted timer state
  logic [15:0]      tmr_count;
  logic [15:0]      tmr_latch;
  logic             tmr_run;
  logic             tmr_oneshot;
  itv16_pkg::pend_t tmr_pend [StartDelay];

  // result words still owed by the block, oldest first
  itv16_pkg::result_t timer_result_q [$];

  always #2 clk_i = ~clk_i;

  interval_timer_16bit_top #(
    .START_DELAY(StartDelay)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .data_i      (data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_value_o(read_value_o),
    .underflow_o (underflow_o),
    .is_running_o(is_running_o)
  );

  // one count step; a step from zero reloads, stops a one-shot timer and reports the underflow
  function automatic logic count_down();
    if (tmr_count == 16'h0000) begin
      tmr_count = tmr_latch;
      if (tmr_oneshot) tmr_run = 1'b0;
      return 1'b1;
    end
    tmr_count = tmr_count - 16'd1;
    return 1'b0;
  endfunction

  // advances the predicted timer by one word and returns the result word it owes
  function automatic itv16_pkg::result_t predict_timer_word(logic [2:0] op, logic [7:0] data);
    itv16_pkg::result_t res;
    itv16_pkg::pend_t   leaving;
    int                 i;
    res = '0;
    case (op)
      itv16_pkg::OP_TICK: begin
        // count with the run state from before the tick, then shift the requests
        if (tmr_run) res.underflow = count_down();
        leaving = tmr_pend[StartDelay-1];
        for (i = StartDelay - 1; i > 0; i--) tmr_pend[i] = tmr_pend[i-1];
        tmr_pend[0] = '0;
        if (leaving.valid) begin
          if (leaving.load) tmr_count = tmr_latch;
          tmr_run = leaving.run;
        end
      end
      itv16_pkg::OP_LATCH_LO: begin
        tmr_latch[7:0] = data;
        if (!tmr_run) tmr_count = tmr_latch;
      end
      itv16_pkg::OP_LATCH_HI: begin
        tmr_latch[15:8] = data;
        if (!tmr_run) tmr_count = tmr_latch;
      end
      itv16_pkg::OP_CONTROL: begin
        // one-shot takes effect at once, the rest waits in the request pipe
        tmr_oneshot = data[itv16_pkg::CtrlOneshotBit];
        tmr_pend[0] = '{load:  data[itv16_pkg::CtrlLoadBit],
                        run:   data[itv16_pkg::CtrlStartBit],
                        valid: 1'b1};
      end
      itv16_pkg::OP_READ: res.read_value = (tmr_count == 16'h0000) ? tmr_latch : tmr_count;
      itv16_pkg::OP_PULSE: res.underflow = count_down();
      default: ;
    endcase
    res.is_running = tmr_run;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got 0x%04h want 0x%04h", cycle_count, what, got, want);
  endtask

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, or a solid hold-off while hold_left runs down
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: check the output word first, it always belongs to an older input word
  always @(posedge clk_i) begin
    itv16_pkg::result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (timer_result_q.size() == 0) begin
          report_mismatch("result word with none pending", read_value_o, 16'h0000);
        end else begin
          want = timer_result_q.pop_front();
          results_checked++;
          if (read_value_o !== want.read_value)
            report_mismatch("read_value", read_value_o, want.read_value);
          if (underflow_o !== want.underflow)
            report_mismatch("underflow", 16'(underflow_o), 16'(want.underflow));
          if (is_running_o !== want.is_running)
            report_mismatch("is_running", 16'(is_running_o), 16'(want.is_running));
          if (want.underflow) underflows_seen++;
        end
      end
      if (in_valid_i && in_stall_o) in_stall_cycles++;
      if (in_valid_i && !in_stall_o) begin
        if (op_i == itv16_pkg::OP_READ) reads_seen++;
        timer_result_q.push_back(predict_timer_word(op_i, data_i));
      end
    end
  end

  // offers one word, entered and left at a falling edge; valid stays up for the next word
  task automatic send_word(input logic [2:0] op, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    data_i     <= data;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (op != OpSpare6 && op != OpSpare7) words_sent++;
  endtask

  // corner cases from reset: short periods, queued requests, one-shot, pulses, spare codes
  task automatic test_directed();
    send_word(itv16_pkg::OP_READ, 8'h00);         // all ones after reset
    send_word(itv16_pkg::OP_LATCH_LO, 8'h02);     // stopped, so the counter follows the latch
    send_word(itv16_pkg::OP_LATCH_HI, 8'h00);
    send_word(itv16_pkg::OP_READ, 8'hff);
    send_word(itv16_pkg::OP_CONTROL, 8'h10);      // load request replaced by the start below
    send_word(itv16_pkg::OP_CONTROL, 8'h01);
    repeat (6) send_word(itv16_pkg::OP_TICK, 8'h00);  // start lands, then 2, 1, 0, reload
    send_word(itv16_pkg::OP_READ, 8'h00);
    send_word(itv16_pkg::OP_CONTROL, 8'h00);      // stop and start back to back
    send_word(itv16_pkg::OP_TICK, 8'hff);
    send_word(itv16_pkg::OP_CONTROL, 8'h19);      // start, force load, one-shot
    repeat (5) send_word(itv16_pkg::OP_TICK, 8'h00);
    send_word(itv16_pkg::OP_PULSE, 8'h00);
    send_word(itv16_pkg::OP_CONTROL, 8'h10);      // force load while stopped
    send_word(itv16_pkg::OP_TICK, 8'h00);
    send_word(itv16_pkg::OP_TICK, 8'h00);
    send_word(itv16_pkg::OP_LATCH_LO, 8'h00);     // zero latch: a read shows the latch
    send_word(itv16_pkg::OP_READ, 8'h00);
    send_word(itv16_pkg::OP_PULSE, 8'h00);        // pulse from zero while stopped
    send_word(OpSpare6, 8'hff);
    send_word(OpSpare7, 8'h5a);
    send_word(itv16_pkg::OP_LATCH_HI, 8'hff);
    send_word(itv16_pkg::OP_LATCH_LO, 8'hff);
  endtask

  // mostly reprogram-and-run bursts with short periods, plus some noise
  task automatic test_random_words(input int unsigned n);
    int unsigned target;
    int unsigned pick;
    logic [7:0]  byte_val;
    target = words_sent + n;
    while (words_sent < target) begin
      if ($urandom_range(99) < 70) begin
        byte_val = 8'($urandom_range(255));
        byte_val[itv16_pkg::CtrlStartBit] = 1'b0;
        send_word(itv16_pkg::OP_CONTROL, byte_val);
        send_word(itv16_pkg::OP_TICK, 8'($urandom_range(255)));
        send_word(itv16_pkg::OP_TICK, 8'($urandom_range(255)));
        send_word(itv16_pkg::OP_LATCH_LO, 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                                       : $urandom_range(12)));
        send_word(itv16_pkg::OP_LATCH_HI,
                  8'(($urandom_range(7) == 0) ? $urandom_range(255) : 0));
        byte_val = 8'($urandom_range(255));
        byte_val[itv16_pkg::CtrlStartBit] = ($urandom_range(9) != 0);
        send_word(itv16_pkg::OP_CONTROL, byte_val);
        repeat ($urandom_range(4, 40)) begin
          pick = $urandom_range(99);
          if (pick < 70)      send_word(itv16_pkg::OP_TICK, 8'($urandom_range(255)));
          else if (pick < 84) send_word(itv16_pkg::OP_READ, 8'($urandom_range(255)));
          else if (pick < 92) send_word(itv16_pkg::OP_PULSE, 8'($urandom_range(255)));
          else if (pick < 96) send_word(itv16_pkg::OP_CONTROL, 8'($urandom_range(255)));
          else if (pick < 98) send_word(itv16_pkg::OP_LATCH_LO, 8'($urandom_range(255)));
          else                send_word(itv16_pkg::OP_LATCH_HI, 8'($urandom_range(255)));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_word(3'($urandom_range(7)), 8'($urandom_range(255)));
      end
    end
  endtask

  // output blocked for a long stretch while words keep coming, so the input stalls
  task automatic test_output_hold_off();
    @(posedge clk_i);
    hold_left = HoldOffLen;
    @(negedge clk_i);
    repeat (40)
      send_word(3'($urandom_range(itv16_pkg::OP_PULSE)), 8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned i;
    // model state at reset
    tmr_count   = itv16_pkg::CountReset;
    tmr_latch   = itv16_pkg::CountReset;
    tmr_run     = 1'b0;
    tmr_oneshot = 1'b0;
    for (i = 0; i < StartDelay; i++) tmr_pend[i] = '0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();

    // receiver stalls more than the sender idles, then the reverse, then no idling
    send_idle_pct  = 33;
    recv_stall_pct = 63;
    test_random_words(550);
    send_idle_pct  = 63;
    recv_stall_pct = 33;
    test_random_words(550);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_output_hold_off();
    test_random_words(600);

    in_valid_i <= 1'b0;
    while (timer_result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (timer_result_q.size() != 0)
      report_mismatch("result words never arrived", 16'h0000, 16'(timer_result_q.size()));

    $display("sent %0d words, checked %0d results: %0d reads, %0d underflows",
             words_sent, results_checked, reads_seen, underflows_seen);
    $display("input held back for %0d cycles by output back-pressure", in_stall_cycles);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
sv/itv16_pkg.sv
sv/itv16_core.sv
sv/interval_timer_16bit_top.sv
tb/sv/tb.sv
